@@ src/hctb_pkg.sv @@
// ----------------------------------------------------------------------------
// hctb_pkg
// Shared types and constants of the canonical Huffman code table builder.
// ----------------------------------------------------------------------------
package hctb_pkg;

	localparam int KIND_W           = 2;
	localparam int SYM_W            = 8;
	localparam int COUNT_W          = 8;
	localparam int LEN_W            = 5;
	localparam int CODE_W           = 16;
	localparam int ERR_W            = 3;
	localparam int LI_IDX_W         = 4;
	localparam int TOTAL_W          = 9;
	localparam int WCODE_W          = 17;
	localparam int DC_SYMBOL_MAX    = 15;
	localparam int QUEUE_DEPTH      = 2;
	localparam int DEF_MAX_CODE_LEN = 16;
	localparam int DEF_SYMBOL_COUNT = 256;

	typedef enum logic [KIND_W-1:0] {
		OP_BEGIN  = 2'd0,
		OP_COUNT  = 2'd1,
		OP_SYMBOL = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE          = 3'd0,
		ERR_COUNT_OVERRUN = 3'd1,
		ERR_CODE_OVERFLOW = 3'd2,
		ERR_SYMBOL_RANGE  = 3'd3,
		ERR_TOO_MANY      = 3'd4
	} err_t;

	typedef struct packed {
		op_t                  op;
		logic                 dc_table;
		logic                 li_ok;
		logic [LI_IDX_W-1:0]  li_idx;
		logic [COUNT_W-1:0]   count;
		logic [SYM_W-1:0]     symbol;
		logic                 sym_ok;
		logic                 sym_dc;
	} cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

@@ src/hctb_front.sv @@
// ----------------------------------------------------------------------------
// hctb_front
// Input stage: accepts items, decodes the kind and precomputes range checks.
// ----------------------------------------------------------------------------
module hctb_front
	import hctb_pkg::*;
#(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic               dc_table,
	input  logic [LEN_W-1:0]   length_index,
	input  logic [COUNT_W-1:0] count,
	input  logic [SYM_W-1:0]   symbol,
	output logic               push,
	output cmd_t               push_cmd,
	input  logic               queue_full
);

	logic             valid_s1;
	cmd_t             cmd_s1;
	cmd_t             cmd_d;
	logic [LEN_W-1:0] li_m1;

	assign in_stall = valid_s1 && queue_full;
	assign push     = valid_s1 && !queue_full;
	assign push_cmd = cmd_s1;
	assign li_m1    = length_index - LEN_W'(1);

	always_comb begin
		cmd_d          = '0;
		cmd_d.op       = op_t'(kind);
		cmd_d.dc_table = dc_table;
		cmd_d.li_ok    = (length_index != '0) && (length_index <= LEN_W'(MAX_CODE_LEN));
		cmd_d.li_idx   = li_m1[LI_IDX_W-1:0];
		cmd_d.count    = count;
		cmd_d.symbol   = symbol;
		cmd_d.sym_ok   = {1'b0, symbol} < (SYM_W+1)'(SYMBOL_COUNT);
		cmd_d.sym_dc   = symbol <= SYM_W'(DC_SYMBOL_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
		end else begin
			if (push)
				valid_s1 <= 1'b0;
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= cmd_d;
			end
		end
	end

endmodule

@@ src/hctb_queue.sv @@
// ----------------------------------------------------------------------------
// hctb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hctb_queue
	import hctb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full       = fill_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule

@@ src/hctb_back.sv @@
// ----------------------------------------------------------------------------
// hctb_back
// Execution side: count table, canonical code walk, symbol table, result.
// ----------------------------------------------------------------------------
module hctb_back
	import hctb_pkg::*;
#(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SYM_W-1:0]  symbol_out,
	output logic [CODE_W-1:0] code,
	output logic [LEN_W-1:0]  code_length,
	output logic [ERR_W-1:0]  error
);

	localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
	localparam int LEN_IDX_W = $clog2(MAX_CODE_LEN);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_LOOK
	} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic [SYM_W-1:0]     out_sym_q;
	logic [CODE_W-1:0]    out_code_q;
	logic [LEN_W-1:0]     out_len_q;
	err_t                 out_err_q;

	logic [COUNT_W-1:0]   counts_q [MAX_CODE_LEN];
	logic [TOTAL_W-1:0]   total_q;
	logic [TOTAL_W-1:0]   assigned_q;
	logic [LEN_W-1:0]     cur_len_q;
	logic [COUNT_W-1:0]   left_q;
	logic [WCODE_W-1:0]   next_code_q;
	logic                 dc_q;
	logic [SYMBOL_COUNT-1:0] valid_q;

	logic [LEN_W-1:0]     wlen_q;
	logic [COUNT_W-1:0]   wleft_q;
	logic [WCODE_W-1:0]   wcode_q;
	logic [SYM_W-1:0]     sym_q;
	logic                 hit_q;

	entry_t               mem_q [SYMBOL_COUNT];
	entry_t               rd_q;

	logic                 out_free;
	logic [LEN_IDX_W-1:0] rd_idx;
	logic [COUNT_W-1:0]   cnt_rd;
	logic [TOTAL_W:0]     new_total;
	logic                 walk_step;
	logic [WCODE_W-1:0]   code_lim;
	logic                 walk_fail;
	logic [CODE_W-1:0]    wcode_masked;
	logic                 mem_we;
	logic [ADDR_W-1:0]    head_addr;
	logic [ADDR_W-1:0]    sym_addr;
	logic                 sym_bad;
	entry_t               wr_entry;

	assign out_valid   = out_valid_q;
	assign symbol_out  = out_sym_q;
	assign code        = out_code_q;
	assign code_length = out_len_q;
	assign error       = out_err_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && head_valid && out_free;
	assign head_addr = head_cmd.symbol[ADDR_W-1:0];
	assign sym_addr  = sym_q[ADDR_W-1:0];
	assign sym_bad   = !head_cmd.sym_ok || (dc_q && !head_cmd.sym_dc);

	assign rd_idx    = (state_q == ST_WALK) ? wlen_q[LEN_IDX_W-1:0]
	                                        : head_cmd.li_idx[LEN_IDX_W-1:0];
	assign cnt_rd    = counts_q[rd_idx];
	assign new_total = {1'b0, total_q} - (TOTAL_W+1)'(cnt_rd)
	                 + (TOTAL_W+1)'(head_cmd.count);

	assign walk_step    = (wleft_q == '0) && (wlen_q < LEN_W'(MAX_CODE_LEN));
	assign code_lim     = (WCODE_W'(1) << wlen_q) - WCODE_W'(1);
	assign walk_fail    = (wleft_q == '0) || (wlen_q == '0) || (wcode_q >= code_lim);
	assign wcode_masked = wcode_q[CODE_W-1:0] & code_lim[CODE_W-1:0];
	assign mem_we       = (state_q == ST_WALK) && !walk_step && !walk_fail;

	always_comb begin
		wr_entry      = '0;
		wr_entry.code = wcode_masked;
		wr_entry.len  = wlen_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[sym_addr] <= wr_entry;
		rd_q <= mem_q[head_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_sym_q   <= '0;
			out_code_q  <= '0;
			out_len_q   <= '0;
			out_err_q   <= ERR_NONE;
			counts_q    <= '{default: '0};
			total_q     <= '0;
			assigned_q  <= '0;
			cur_len_q   <= '0;
			left_q      <= '0;
			next_code_q <= '0;
			dc_q        <= 1'b0;
			valid_q     <= '0;
			wlen_q      <= '0;
			wleft_q     <= '0;
			wcode_q     <= '0;
			sym_q       <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						out_sym_q  <= '0;
						out_code_q <= '0;
						out_len_q  <= '0;
						out_err_q  <= ERR_NONE;
						case (head_cmd.op)
							OP_BEGIN: begin
								counts_q    <= '{default: '0};
								total_q     <= '0;
								assigned_q  <= '0;
								cur_len_q   <= '0;
								left_q      <= '0;
								next_code_q <= '0;
								valid_q     <= '0;
								dc_q        <= head_cmd.dc_table;
								out_valid_q <= 1'b1;
							end
							OP_COUNT: begin
								if (head_cmd.li_ok && (assigned_q == '0)) begin
									if (new_total > (TOTAL_W+1)'(SYMBOL_COUNT)) begin
										out_err_q <= ERR_COUNT_OVERRUN;
									end else begin
										counts_q[rd_idx] <= head_cmd.count;
										total_q          <= new_total[TOTAL_W-1:0];
									end
								end
								out_valid_q <= 1'b1;
							end
							OP_SYMBOL: begin
								out_sym_q <= head_cmd.symbol;
								if (assigned_q >= total_q) begin
									out_err_q   <= ERR_TOO_MANY;
									out_valid_q <= 1'b1;
								end else if (sym_bad) begin
									out_err_q   <= ERR_SYMBOL_RANGE;
									out_valid_q <= 1'b1;
								end else begin
									wlen_q  <= cur_len_q;
									wleft_q <= left_q;
									wcode_q <= next_code_q;
									sym_q   <= head_cmd.symbol;
									state_q <= ST_WALK;
								end
							end
							OP_LOOKUP: begin
								out_sym_q <= head_cmd.symbol;
								if (!head_cmd.sym_ok) begin
									out_err_q   <= ERR_SYMBOL_RANGE;
									out_valid_q <= 1'b1;
								end else begin
									sym_q   <= head_cmd.symbol;
									hit_q   <= valid_q[head_addr];
									state_q <= ST_LOOK;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_step) begin
						wcode_q <= {wcode_q[WCODE_W-2:0], 1'b0};
						wlen_q  <= wlen_q + LEN_W'(1);
						wleft_q <= cnt_rd;
					end else begin
						out_sym_q   <= sym_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (walk_fail) begin
							out_code_q <= '0;
							out_len_q  <= '0;
							out_err_q  <= ERR_CODE_OVERFLOW;
						end else begin
							out_code_q        <= wcode_masked;
							out_len_q         <= wlen_q;
							out_err_q         <= ERR_NONE;
							valid_q[sym_addr] <= 1'b1;
							cur_len_q         <= wlen_q;
							left_q            <= wleft_q - COUNT_W'(1);
							next_code_q       <= wcode_q + WCODE_W'(1);
							assigned_q        <= assigned_q + TOTAL_W'(1);
						end
					end
				end
				ST_LOOK: begin
					out_sym_q   <= sym_q;
					out_code_q  <= hit_q ? rd_q.code : '0;
					out_len_q   <= hit_q ? rd_q.len : '0;
					out_err_q   <= ERR_NONE;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result register occupied while an item is in flight");

	a_assigned_bound: assert property (@(posedge clk) disable iff (!arst_n)
		assigned_q <= total_q)
		else $error("more symbols assigned than counted");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_W'(SYMBOL_COUNT))
		else $error("count total above symbol count");

	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (wlen_q <= LEN_W'(MAX_CODE_LEN)))
		else $error("code walk beyond maximum length");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (out_valid_q && out_err_q == ERR_NONE && out_len_q != '0))
		else $error("table write without a good result");

endmodule

@@ src/huffman_code_table_builder_unit.sv @@
// ----------------------------------------------------------------------------
// huffman_code_table_builder_unit
// Builds and serves a canonical JPEG Huffman encode table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one item per handshake: begin,
// length count, next symbol or lookup. Output channel (out_valid / out_stall)
// returns exactly one result item per input item, in order.
// An input register and a two-entry command queue sit in front of the
// execution side, so items keep being taken while a result waits.
// Begin and count items execute directly; lookup adds one registered read
// of the symbol table; next symbol runs a canonical walk that steps over
// the empty code lengths (at most MAX_CODE_LEN) before its result.
// Reset empties the queue and clears the count table, the walk state and
// the per-symbol valid bits; a begin item clears them again.
// With out_stall high the result holds; the queue fills and then in_stall
// rises.
// ----------------------------------------------------------------------------
module huffman_code_table_builder_unit
	import hctb_pkg::*;
#(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic               dc_table,
	input  logic [LEN_W-1:0]   length_index,
	input  logic [COUNT_W-1:0] count,
	input  logic [SYM_W-1:0]   symbol,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SYM_W-1:0]   symbol_out,
	output logic [CODE_W-1:0]  code,
	output logic [LEN_W-1:0]   code_length,
	output logic [ERR_W-1:0]   error
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	hctb_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.dc_table     (dc_table),
		.length_index (length_index),
		.count        (count),
		.symbol       (symbol),
		.push         (push),
		.push_cmd     (push_cmd),
		.queue_full   (queue_full)
	);

	hctb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	hctb_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol_out  (symbol_out),
		.code        (code),
		.code_length (code_length),
		.error       (error)
	);

endmodule
